### src/etdt_pkg.sv
// Package for the extended timecount down timer.
// Holds the item, register and configuration types and shared constants.
// No dependencies.
`default_nettype none

package etdt_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int ADDR_W           = 4;
    localparam int DATA_W           = 32;
    localparam int PRESCALE_W       = 8;
    localparam int RELOAD_W         = 17;
    localparam int TPM_W            = 16;
    localparam int US_W             = 32;
    localparam int PROD_W           = TPM_W + US_W;
    localparam int TC_W             = 32;
    localparam int CV_W             = 16;
    localparam int DIV_W            = 4;
    localparam int THRESH_W         = 43;
    localparam int US_PER_MS        = 1000;

    localparam logic [PRESCALE_W-1:0] PRESCALE_RST = 8'd1;
    localparam logic [RELOAD_W-1:0]   RELOAD_RST   = 17'd65536;
    localparam logic [TPM_W-1:0]      TPM_RST      = 16'd0;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ACK   = 2'd1,
        OP_READ  = 2'd2,
        OP_DELAY = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_PRESCALE = 2'd0,
        REG_RELOAD   = 2'd1,
        REG_TICKS    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        op_t              op;
        logic [US_W-1:0]  delay_us;
    } cmd_t;

    typedef struct packed {
        logic [TC_W-1:0]  timecount;
        logic [CV_W-1:0]  counter_value;
        logic             irq_pending;
        logic             delay_busy;
    } res_t;

    typedef struct packed {
        logic [PRESCALE_W-1:0] prescale_minus_one;
        logic [RELOAD_W-1:0]   reload_value;
        logic [TPM_W-1:0]      ticks_per_ms;
    } cfg_t;

endpackage

`default_nettype wire

### src/extended_timecount_down_timer.sv
// Top level of the extended timecount down timer: command pipeline, APB registers.
// Path from command accept to result valid: input stage, multiply stage, timer update
// into the result register. Throughput: one item per cycle unless res_stall holds it.
// The delay conversion multiply has its own stage ahead of the timer update.
// Reset: asynchronous, active low; all pipeline stages empty, registers at reset values.
`default_nettype none

module extended_timecount_down_timer #(
    parameter int COUNTER_BITS = etdt_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire etdt_pkg::cmd_t              cmd,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output etdt_pkg::res_t                   res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [etdt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [etdt_pkg::DATA_W-1:0] pwdata,
    output logic [etdt_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import etdt_pkg::*;

    cfg_t             cfg_reg;
    reg_idx_t         reg_idx;
    logic             cfg_wr;

    logic             s1_v_reg;
    op_t              s1_op_reg;
    logic [US_W-1:0]  s1_us_reg;
    logic             s2_v_reg;
    op_t              s2_op_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [PROD_W-1:0] s2_prod_next;
    logic             res_v_reg;
    res_t             res_reg;
    res_t             res_next;

    logic             s1_ld;
    logic             s2_ld;
    logic             res_ld;
    logic             exec;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescale_minus_one <= PRESCALE_RST;
            cfg_reg.reload_value       <= RELOAD_RST;
            cfg_reg.ticks_per_ms       <= TPM_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_PRESCALE: cfg_reg.prescale_minus_one <= pwdata[PRESCALE_W-1:0];
                REG_RELOAD:   cfg_reg.reload_value       <= pwdata[RELOAD_W-1:0];
                REG_TICKS:    cfg_reg.ticks_per_ms       <= pwdata[TPM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PRESCALE: prdata = DATA_W'(cfg_reg.prescale_minus_one);
            REG_RELOAD:   prdata = DATA_W'(cfg_reg.reload_value);
            REG_TICKS:    prdata = DATA_W'(cfg_reg.ticks_per_ms);
            default:      prdata = '0;
        endcase
    end

    assign res_ld    = !res_v_reg || !res_stall;
    assign s2_ld     = !s2_v_reg || res_ld;
    assign s1_ld     = !s1_v_reg || s2_ld;
    assign exec      = s2_v_reg && res_ld;
    assign cmd_stall = !s1_ld;

    assign s2_prod_next = PROD_W'(cfg_reg.ticks_per_ms) * PROD_W'(s1_us_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ld)
            begin
                s1_v_reg <= cmd_valid;
            end
            if (s2_ld)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (res_ld)
            begin
                res_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ld && cmd_valid)
        begin
            s1_op_reg <= cmd.op;
            s1_us_reg <= cmd.delay_us;
        end
        if (s2_ld && s1_v_reg)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_prod_reg <= s2_prod_next;
        end
        if (exec)
        begin
            res_reg <= res_next;
        end
    end

    etdt_timer #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_timer (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .exec     (exec),
        .op       (s2_op_reg),
        .prod     (s2_prod_reg),
        .res_next (res_next)
    );

    assign res_valid = res_v_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### src/etdt_timer.sv
// Timer state and per-item update for the extended timecount down timer.
// Holds the divider, prescaler, down counter, base, pending flag and delay tracking.
// Depends on etdt_pkg.
`default_nettype none

module etdt_timer #(
    parameter int COUNTER_BITS = etdt_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire etdt_pkg::cfg_t              cfg,
    input  wire logic                        exec,
    input  wire etdt_pkg::op_t               op,
    input  wire logic [etdt_pkg::PROD_W-1:0] prod,
    output etdt_pkg::res_t                   res_next
);
    import etdt_pkg::*;

    localparam int CB    = COUNTER_BITS;
    localparam int REL_W = CB + 1;
    localparam int CMP_W = (REL_W > RELOAD_W) ? REL_W : RELOAD_W;
    localparam int EXT_W = (REL_W > TC_W) ? REL_W : TC_W;
    localparam logic [CB-1:0] DOWN_RST =
        (CB >= 16) ? CB'(int'(RELOAD_RST) - 1) : {CB{1'b1}};

    logic [DIV_W-1:0]      div_reg, div_next;
    logic [PRESCALE_W-1:0] pres_reg, pres_next;
    logic [CB-1:0]         down_reg, down_next;
    logic [TC_W-1:0]       base_reg, base_next;
    logic                  pend_reg, pend_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [THRESH_W-1:0]   thresh_reg, thresh_next;
    logic [US_W-1:0]       elapsed_reg, elapsed_next;
    logic                  busy_reg, busy_next;

    logic [CMP_W-1:0] rv_ext;
    logic [CMP_W-1:0] top_ext;
    logic [CMP_W-1:0] eff_ext;
    logic [REL_W-1:0] rel;
    logic [CB-1:0]    rel_m1;
    logic             cnt_tick;

    always_comb
    begin
        rv_ext  = CMP_W'(cfg.reload_value);
        top_ext = CMP_W'(1) << CB;
        if (rv_ext == '0)
        begin
            eff_ext = CMP_W'(1);
        end
        else if (rv_ext > top_ext)
        begin
            eff_ext = top_ext;
        end
        else
        begin
            eff_ext = rv_ext;
        end
        rel    = REL_W'(eff_ext);
        rel_m1 = CB'(rel - REL_W'(1));
    end

    always_comb
    begin
        div_next     = div_reg;
        pres_next    = pres_reg;
        down_next    = down_reg;
        base_next    = base_reg;
        pend_next    = pend_reg;
        prod_next    = prod_reg;
        thresh_next  = thresh_reg;
        elapsed_next = elapsed_reg;
        busy_next    = busy_reg;
        cnt_tick     = 1'b0;

        unique case (op)
            OP_TICK:
            begin
                div_next = div_reg + DIV_W'(1);
                if (div_reg == {DIV_W{1'b1}})
                begin
                    if (pres_reg >= cfg.prescale_minus_one)
                    begin
                        pres_next = '0;
                        cnt_tick  = 1'b1;
                    end
                    else
                    begin
                        pres_next = pres_reg + PRESCALE_W'(1);
                    end
                end
            end
            OP_ACK:
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    base_next = base_reg + TC_W'(rel);
                end
            end
            OP_READ:
            begin
            end
            OP_DELAY:
            begin
                prod_next    = prod;
                elapsed_next = '0;
                thresh_next  = THRESH_W'(2 * US_PER_MS);
                busy_next    = (prod >= PROD_W'(US_PER_MS));
            end
            default:
            begin
            end
        endcase

        if (cnt_tick)
        begin
            if (down_reg == '0)
            begin
                down_next = rel_m1;
                pend_next = 1'b1;
            end
            else
            begin
                down_next = down_reg - CB'(1);
            end
            if (busy_reg)
            begin
                elapsed_next = elapsed_reg + US_W'(1);
                thresh_next  = thresh_reg + THRESH_W'(US_PER_MS);
                busy_next    = (elapsed_next != {US_W{1'b1}})
                            && (prod_reg >= PROD_W'(thresh_reg));
            end
        end
    end

    always_comb
    begin
        res_next.timecount     = TC_W'(EXT_W'(base_next) - EXT_W'(down_next)
                                 + (pend_next ? EXT_W'(rel) : EXT_W'(0)));
        res_next.counter_value = CV_W'(down_next);
        res_next.irq_pending   = pend_next;
        res_next.delay_busy    = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg     <= '0;
            pres_reg    <= '0;
            down_reg    <= DOWN_RST;
            base_reg    <= '0;
            pend_reg    <= 1'b0;
            prod_reg    <= '0;
            thresh_reg  <= '0;
            elapsed_reg <= '0;
            busy_reg    <= 1'b0;
        end
        else if (exec)
        begin
            div_reg     <= div_next;
            pres_reg    <= pres_next;
            down_reg    <= down_next;
            base_reg    <= base_next;
            pend_reg    <= pend_next;
            prod_reg    <= prod_next;
            thresh_reg  <= thresh_next;
            elapsed_reg <= elapsed_next;
            busy_reg    <= busy_next;
        end
    end

    a_busy_below_sat: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (elapsed_reg != {US_W{1'b1}}))
        else $error("delay busy with elapsed count at saturation");

    a_busy_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (prod_reg >= PROD_W'(thresh_reg - THRESH_W'(US_PER_MS))))
        else $error("delay busy below its tick threshold");

    a_pend_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> $past(exec && op == OP_TICK && down_reg == '0))
        else $error("pending set without a wrap");

    a_base_ack: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(base_reg) |-> $past(exec && op == OP_ACK && pend_reg))
        else $error("base changed without an acknowledge");

endmodule

`default_nettype wire
